### rtl/core/uint_to_ascii_radix_unit_macros.svh
// ----------------------------------------------------------------------------
// uint_to_ascii_radix_unit_macros
// Assertion macros shared by the radix conversion unit.
// ----------------------------------------------------------------------------
`ifndef UINT_TO_ASCII_RADIX_UNIT_MACROS_SVH
`define UINT_TO_ASCII_RADIX_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define UTAR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define UTAR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/utar_pkg.sv
// ----------------------------------------------------------------------------
// utar_pkg
// Types, sizes and helpers of the unsigned-to-ASCII radix converter.
// ----------------------------------------------------------------------------
package utar_pkg;

  localparam int VALUE_WIDTH = 64;

  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int TOTAL_W   = 7;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 16;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
  localparam logic [DIGIT_W-1:0] DEC_BASE   = 6'd10;
  localparam int                 ALPHA_CNT  = 26;

  // long division: quotient bits resolved per cycle
  localparam int DIV_STEPS = 8;
  localparam int DIV_CYC   = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W     = DIV_CYC * DIV_STEPS;
  localparam int CYC_W     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W = $clog2(VALUE_WIDTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;
  } job_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_BASE) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DEC_BASE);
    end
    return c;
  endfunction

endpackage

### rtl/core/utar_front.sv
// ----------------------------------------------------------------------------
// utar_front
// Input stage: accepts a beat, masks the value and clamps the radix.
// ----------------------------------------------------------------------------
module utar_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [63:0] value, [69:64] radix, [71:70] zero
  input  logic [utar_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output utar_pkg::job_t                job_o
);
  import utar_pkg::*;

  logic                   full_q, full_d;
  job_t                   job_q;
  logic                   accept;
  logic [RADIX_W-1:0]     radix_raw;
  logic [RADIX_W-1:0]     radix_clamped;

  assign s_axis_tready_o = !full_q || job_ready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign radix_raw       = s_axis_tdata_i[64 +: RADIX_W];

  always_comb begin
    if (radix_raw < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (radix_raw > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = radix_raw;
    end
  end

  always_comb begin
    full_d = full_q;
    if (accept) begin
      full_d = 1'b1;
    end else if (job_ready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.value <= s_axis_tdata_i[VALUE_WIDTH-1:0];
      job_q.radix <= radix_clamped;
    end
  end

  assign job_valid_o = full_q;
  assign job_o       = job_q;

endmodule

### rtl/core/utar_fifo.sv
// ----------------------------------------------------------------------------
// utar_fifo
// Short job queue between the input stage and the conversion engine.
// ----------------------------------------------------------------------------
module utar_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  utar_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output utar_pkg::job_t pop_job_o
);
  import utar_pkg::*;

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### rtl/core/utar_back.sv
// ----------------------------------------------------------------------------
// utar_back
// Conversion engine: repeated long division by the radix, digits stored
// least significant first, then replayed most significant first.
// ----------------------------------------------------------------------------
module utar_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  output logic                           job_ready_o,
  input  utar_pkg::job_t                 job_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [6:0] digit_char, [13:7] digit_total, [15:14] zero
  output logic [utar_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import utar_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_SHOW = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [DIV_W-1:0]   quo_q, quo_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] rad_q, rad_d;
  logic [CYC_W-1:0]   cyc_q, cyc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [DIGIT_W-1:0] dig_q;
  logic [DIGIT_W-1:0] digit_mem_q [VALUE_WIDTH];

  logic [DIV_W-1:0]   quo_w;
  logic [DIGIT_W-1:0] rem_w;
  logic [DIGIT_W:0]   part;
  logic               take;
  logic               last_cyc;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_ra;

  // eight restoring division steps per cycle
  always_comb begin
    quo_w = quo_q;
    rem_w = rem_q;
    part  = '0;
    take  = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      part  = {rem_w, quo_w[DIV_W-1]};
      take  = part >= {1'b0, rad_q};
      quo_w = {quo_w[DIV_W-2:0], take};
      rem_w = take ? DIGIT_W'(part - {1'b0, rad_q}) : part[DIGIT_W-1:0];
    end
  end

  assign last_cyc = cyc_q == CYC_W'(DIV_CYC - 1);

  always_comb begin
    state_d  = state_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    rad_d    = rad_q;
    cyc_d    = cyc_q;
    cnt_d    = cnt_q;
    rd_ptr_d = rd_ptr_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_ra   = rd_ptr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          quo_d   = DIV_W'(job_i.value);
          rad_d   = job_i.radix;
          rem_d   = '0;
          cyc_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_d = quo_w;
        rem_d = rem_w;
        cyc_d = cyc_q + 1'b1;
        if (last_cyc) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          rem_d  = '0;
          cyc_d  = '0;
          if (quo_w == '0) begin
            rd_ptr_d = cnt_q[ADDR_W-1:0];
            state_d  = ST_RD;
          end
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (m_axis_tready_i) begin
          if (rd_ptr_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            mem_re   = 1'b1;
            mem_ra   = rd_ptr_q - 1'b1;
            rd_ptr_d = rd_ptr_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cyc_q    <= '0;
      cnt_q    <= '0;
      rd_ptr_q <= '0;
    end else begin
      state_q  <= state_d;
      cyc_q    <= cyc_d;
      cnt_q    <= cnt_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    rad_q <= rad_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem_q[cnt_q[ADDR_W-1:0]] <= rem_w;
    end
    if (mem_re) begin
      dig_q <= digit_mem_q[mem_ra];
    end
  end

  assign job_ready_o     = state_q == ST_IDLE;
  assign m_axis_tvalid_o = state_q == ST_SHOW;
  assign m_axis_tlast_o  = rd_ptr_q == '0;
  assign m_axis_tdata_o  = {(M_TDATA_W - CHAR_W - TOTAL_W)'(0), TOTAL_W'(cnt_q),
                            digit_to_ascii(dig_q)};

endmodule

### rtl/core/uint_to_ascii_radix_unit.sv
// ----------------------------------------------------------------------------
// uint_to_ascii_radix_unit
// Unsigned value to uppercase ASCII digits in radix 2..36, MSD first.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tlast
// s_axis   in   [63:0] value, [69:64] radix              -
// m_axis   out  [6:0] digit_char, [13:7] digit_total     last_digit
//
// Each digit is found by long division (8 quotient bits per cycle over the
// 64-bit value); the digits are then replayed, one beat per cycle while
// m_axis_tready_i is high. Reset clears all control state; no clearing
// pass. A stalled output holds the engine, while the input stage and the
// two-entry queue keep taking beats until they fill.
// ----------------------------------------------------------------------------
`include "uint_to_ascii_radix_unit_macros.svh"

module uint_to_ascii_radix_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [63:0] value, [69:64] radix, [71:70] zero
  input  logic [utar_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [6:0] digit_char, [13:7] digit_total, [15:14] zero
  output logic [utar_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import utar_pkg::*;

  logic              fr_valid, fr_ready;
  job_t              fr_job;
  logic              q_valid, q_ready;
  job_t              q_job;
  logic [CHAR_W-1:0] out_char;
  logic [TOTAL_W-1:0] out_total;

  utar_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .job_valid_o     (fr_valid),
    .job_ready_i     (fr_ready),
    .job_o           (fr_job)
  );

  utar_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_job_i   (fr_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_job_o    (q_job)
  );

  utar_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_valid),
    .job_ready_o     (q_ready),
    .job_i           (q_job),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  assign out_char  = m_axis_tdata_o[CHAR_W-1:0];
  assign out_total = m_axis_tdata_o[CHAR_W +: TOTAL_W];

  `UTAR_ASSERT_IMP(a_char_legal, m_axis_tvalid_o, (out_char >= ASCII_ZERO && out_char < ASCII_ZERO + CHAR_W'(DEC_BASE)) || (out_char >= ASCII_A && out_char < ASCII_A + CHAR_W'(ALPHA_CNT)), "digit char out of range")
  `UTAR_ASSERT_IMP(a_total_range, m_axis_tvalid_o, out_total != '0 && out_total <= TOTAL_W'(VALUE_WIDTH), "digit total out of range")
  `UTAR_ASSERT_NXT(a_total_held, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, $stable(out_total), "digit total changed inside a run")

endmodule
